FILE: rtl/deq_pkg.sv
`default_nettype none

package deq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned S_TDATA_W = 32;
  // value_out (32) + entry_count (5), padded to whole bytes
  localparam int unsigned M_TDATA_W = 40;
  // status (2) + found (1)
  localparam int unsigned M_TUSER_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SEARCH     = 3'd4,
    REQ_REVERSE    = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_WAIT,
    ST_SEARCH,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/deq_ram.sv
`default_nettype none

module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue_engine.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit values kept in a ring of DEPTH
// entries in a single synchronous RAM (one write and one registered read port).
// Each input beat carries a request in s_axis_tuser (push front/back, pop
// front/back, search, reverse) and its operand in s_axis_tdata; each request
// yields exactly one output beat with the popped value, a status (ok, empty on
// pop, full on push), a found flag and the entry count after the request.
// Reverse toggles a flag that swaps the physical ends of the ring, so it takes
// effect at once. Push, reverse, rejected requests and unknown codes go from
// ST_IDLE to ST_EMIT, which loads the output register once it is free; a pop
// passes through ST_POP_WAIT for the registered RAM read, and a search walks
// the ring in ST_SEARCH through the single RAM read port one entry per cycle,
// stopping at the first match or after the last entry. The output register
// lets the next request be accepted while a result still waits on m_axis_tready.
// The RAM needs no clearing pass; only written entries ever reach a result.
module double_ended_queue_engine #(
  parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave side
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [deq_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value_in
  input  wire logic [deq_pkg::REQ_W-1:0]      s_axis_tuser,  // [2:0] req_type
  // master side
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [deq_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [31:0] value_out,
                                                              // [36:32] entry_count
  output logic      [deq_pkg::M_TUSER_W-1:0]  m_axis_tuser   // [1:0] status, [2] found
);

  import deq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 2;

  // Architectural state
  state_e               state_q, state_d;
  logic [AW-1:0]        front_q, front_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 rev_q, rev_d;

  // Request operand and search walk
  logic [DATA_W-1:0]    val_q, val_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        srch_q, srch_d;

  // Staged result
  logic [DATA_W-1:0]    res_value_q, res_value_d;
  status_e              res_status_q, res_status_d;
  logic                 res_found_q, res_found_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [DATA_W-1:0]    out_value_q, out_value_d;
  status_e              out_status_q, out_status_d;
  logic                 out_found_q, out_found_d;
  logic [COUNT_W-1:0]   out_count_q, out_count_d;

  // RAM port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DATA_W-1:0]    ram_wdata, ram_rdata;

  deq_ram #(
    .Width (DATA_W),
    .Depth (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Physical slot at a logical offset from the front, wrapping once.
  function automatic logic [AW-1:0] ring_slot(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Shared decode
  logic          in_acc;
  req_e          in_req;
  logic          is_empty, is_full, is_pop, is_search, at_phys_front;
  logic          hit, last, out_free;
  logic [AW-1:0] front_dec;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_req        = req_e'(s_axis_tuser);
  assign is_empty      = (cnt_q == '0);
  assign is_full       = (cnt_q >= CW'(DEPTH));
  assign is_pop        = (in_req == REQ_POP_FRONT) || (in_req == REQ_POP_BACK);
  assign is_search     = (in_req == REQ_SEARCH);
  assign at_phys_front = ((in_req == REQ_PUSH_FRONT) || (in_req == REQ_POP_FRONT)) != rev_q;
  assign hit           = (ram_rdata == val_q);
  assign last          = (srch_q == cnt_q - CW'(1));
  assign out_free      = !out_valid_q || m_axis_tready;
  assign front_dec     = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
  assign cnt_ext       = {{COUNT_W{1'b0}}, cnt_q};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_pop && !is_empty) begin
            state_d = ST_POP_WAIT;
          end else if (is_search && !is_empty) begin
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_POP_WAIT: state_d = ST_EMIT;
      ST_SEARCH: begin
        if (hit || last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);

    ram_we    = 1'b0;
    ram_waddr = front_q;
    ram_wdata = s_axis_tdata[DATA_W-1:0];
    ram_raddr = front_q;

    front_d = front_q;
    cnt_d   = cnt_q;
    rev_d   = rev_q;
    val_d   = val_q;
    ptr_d   = ptr_q;
    srch_d  = srch_q;

    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;

    out_valid_d  = out_valid_q && !m_axis_tready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          val_d        = s_axis_tdata[DATA_W-1:0];
          res_value_d  = '0;
          res_status_d = STAT_OK;
          res_found_d  = 1'b0;
          unique case (in_req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (is_full) begin
                res_status_d = STAT_FULL;
              end else begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
                if (at_phys_front) begin
                  ram_waddr = front_dec;
                  front_d   = front_dec;
                end else begin
                  ram_waddr = ring_slot(front_q, cnt_q);
                end
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (is_empty) begin
                res_status_d = STAT_EMPTY;
              end else begin
                cnt_d = cnt_q - 1'b1;
                if (at_phys_front) begin
                  ram_raddr = front_q;
                  front_d   = slot_inc(front_q);
                end else begin
                  ram_raddr = ring_slot(front_q, cnt_q - CW'(1));
                end
              end
            end
            REQ_SEARCH: begin
              // issue the read of the front entry, compare starts next cycle
              ram_raddr = front_q;
              ptr_d     = slot_inc(front_q);
              srch_d    = '0;
            end
            REQ_REVERSE: rev_d = !rev_q;
            default: ;
          endcase
        end
      end
      ST_POP_WAIT: res_value_d = ram_rdata;
      ST_SEARCH: begin
        // compare the entry on the read port, prefetch the next one
        ram_raddr = ptr_q;
        ptr_d     = slot_inc(ptr_q);
        srch_d    = srch_q + 1'b1;
        if (hit) begin
          res_found_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          out_found_d  = res_found_q;
          out_count_d  = cnt_ext[COUNT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      cnt_q       <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    ptr_q        <= ptr_d;
    srch_q       <= srch_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - COUNT_W){1'b0}}, out_count_q, out_value_q};
  assign m_axis_tuser  = {out_found_q, out_status_q};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CW'(DEPTH)) && (front_q <= AW'(DEPTH - 1)))
    else $error("queue count or front pointer out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ((s_axis_tuser == REQ_PUSH_FRONT) || (s_axis_tuser == REQ_PUSH_BACK))
     && (cnt_q < CW'(DEPTH)))
    |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("accepted push did not add an entry");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STAT_EMPTY))
    |-> ((out_value_q == '0) && !out_found_q))
    else $error("empty pop result carries data");
`endif

endmodule

`default_nettype wire

FILE: tb/deq_checker.sv
`default_nettype none

module deq_checker
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  input  wire logic                 s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // [31:0] value_in
  input  wire logic [REQ_W-1:0]     s_axis_tuser,  // [2:0] req_type
  input  wire logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire logic [M_TDATA_W-1:0] m_axis_tdata,  // [31:0] value_out, [36:32] entry_count
  input  wire logic [M_TUSER_W-1:0] m_axis_tuser,  // [1:0] status, [2] found
  output int                        fail_count_o,
  output int                        pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0]  value;
    status_e            status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } deq_result_t;

  // shadow of the ring: physical slots, head slot, fill level, reversed order
  logic [DATA_W-1:0] ring [DEPTH];
  int unsigned       head_slot = 0;
  int unsigned       fill = 0;
  logic              flipped = 1'b0;

  deq_result_t awaited_results [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic deq_result_t apply_request(logic [REQ_W-1:0] code,
                                                logic [DATA_W-1:0] operand);
    deq_result_t r;
    logic        at_head;
    r = '{value: '0, status: STAT_OK, found: 1'b0, count: '0};
    case (code)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill == DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          at_head = (code == REQ_PUSH_FRONT) ^ flipped;
          if (at_head) begin
            head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
            ring[head_slot] = operand;
          end else begin
            ring[(head_slot + fill) % DEPTH] = operand;
          end
          fill++;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          at_head = (code == REQ_POP_FRONT) ^ flipped;
          if (at_head) begin
            r.value   = ring[head_slot];
            head_slot = (head_slot + 1) % DEPTH;
          end else begin
            r.value = ring[(head_slot + fill - 1) % DEPTH];
          end
          fill--;
        end
      end
      REQ_SEARCH: begin
        for (int i = 0; i < fill; i++) begin
          if (ring[(head_slot + i) % DEPTH] == operand) begin
            r.found = 1'b1;
            break;
          end
        end
      end
      REQ_REVERSE: flipped = ~flipped;
      default: ;
    endcase
    r.count = COUNT_W'(fill);
    return r;
  endfunction

  task automatic check_field(string tag, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    deq_result_t want;
    if (!rst_ni) begin
      head_slot = 0;
      fill      = 0;
      flipped   = 1'b0;
      awaited_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h/%h",
                   $time, m_axis_tdata, m_axis_tuser);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("value_out", want.value, m_axis_tdata[31:0]);
          check_field("entry_count", DATA_W'(want.count), DATA_W'(m_axis_tdata[36:32]));
          check_field("status", DATA_W'(want.status), DATA_W'(m_axis_tuser[1:0]));
          check_field("found", DATA_W'(want.found), DATA_W'(m_axis_tuser[2]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(apply_request(s_axis_tuser, s_axis_tdata[DATA_W-1:0]));
    end
    pending_o <= awaited_results.size();
  end

endmodule

`default_nettype wire

FILE: tb/tb_double_ended_queue_engine.sv
`default_nettype none

module tb_double_ended_queue_engine;

  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = DEPTH_DEFAULT;

  // request codes the block treats as no-ops
  localparam logic [REQ_W-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD7 = 3'd7;

  localparam logic [DATA_W-1:0] VAL_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX  = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VAL_ZERO = 32'h0000_0000;
  localparam logic [DATA_W-1:0] VAL_NEG1 = 32'hffff_ffff;

  localparam int RANDOM_ITEMS = 800;
  localparam int POOL_MAX     = 24;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_PROBE} mix_mode_e;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // [31:0] value_in
  logic [REQ_W-1:0]     s_axis_tuser  = '0;  // [2:0] req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // [31:0] value_out, [36:32] entry_count
  logic [M_TUSER_W-1:0] m_axis_tuser;        // [1:0] status, [2] found

  int fail_count;
  int pending;

  // drop the idle gaps on one side when set
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  // recently pushed values, so that searches hit as well as miss
  logic [DATA_W-1:0] pushed_pool [$];

  double_ended_queue_engine #(.DEPTH(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  deq_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hold one request beat on the slave side until it is taken. Leave tvalid
  // high on return so back-to-back beats need no second assignment.
  task automatic send_req(input logic [REQ_W-1:0] code, input logic [DATA_W-1:0] operand);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= code;
    s_axis_tdata  <= operand;
    do @(posedge clk_i); while (!s_axis_tready);
    if (code == REQ_PUSH_FRONT || code == REQ_PUSH_BACK) begin
      pushed_pool.push_back(operand);
      if (pushed_pool.size() > POOL_MAX) void'(pushed_pool.pop_front());
    end
  endtask

  // Stop sending and wait until every result has drained from the block.
  task automatic drain_pause();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Mostly random words, some extremes, some recently pushed values.
  function automatic logic [DATA_W-1:0] draw_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return VAL_ZERO;
        default: return VAL_NEG1;
      endcase
    end
    if (pick < 4 && pushed_pool.size() != 0)
      return pushed_pool[$urandom_range(0, pushed_pool.size() - 1)];
    return $urandom;
  endfunction

  // Weight the request mix by mode so the queue swings between empty and full.
  function automatic logic [REQ_W-1:0] draw_request(mix_mode_e mode);
    int roll;
    int push_cut;
    int pop_cut;
    case (mode)
      MODE_FILL:  begin push_cut = 28; pop_cut = 34; end
      MODE_DRAIN: begin push_cut = 10; pop_cut = 34; end
      MODE_MIX:   begin push_cut = 20; pop_cut = 32; end
      default:    begin push_cut = 14; pop_cut = 22; end
    endcase
    roll = $urandom_range(0, 39);
    if (roll == 0)
      return ($urandom_range(0, 1) != 0) ? REQ_RSVD7 : REQ_RSVD6;
    if (roll < 4)
      return REQ_REVERSE;
    if (roll < push_cut)
      return ($urandom_range(0, 1) != 0) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    if (roll < pop_cut)
      return ($urandom_range(0, 1) != 0) ? REQ_POP_BACK : REQ_POP_FRONT;
    return REQ_SEARCH;
  endfunction

  // Master side: before each beat, drop tready for a random stall unless rx_burst
  // is set, then hold tready high until the result beat is taken.
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Bound the run in case the block hangs.
  initial begin
    #5_000_000;
    $display("FAIL double_ended_queue_engine");
    $finish;
  end

  initial begin
    int        sent;
    int        seg_len;
    bit        paused;
    mix_mode_e mode;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue corner cases and an unknown code.
    send_req(REQ_POP_FRONT, VAL_ZERO);
    send_req(REQ_POP_BACK, VAL_NEG1);
    send_req(REQ_SEARCH, VAL_ZERO);
    send_req(REQ_REVERSE, VAL_MAX);
    send_req(REQ_RSVD7, VAL_MIN);

    // Fill to capacity from both ends with the extreme values mixed in.
    send_req(REQ_PUSH_FRONT, VAL_MIN);
    send_req(REQ_PUSH_BACK, VAL_MAX);
    send_req(REQ_PUSH_FRONT, VAL_ZERO);
    send_req(REQ_PUSH_BACK, VAL_NEG1);
    for (int i = 4; i < DEPTH; i++)
      send_req((i % 2 != 0) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, $urandom);

    // Push into a full queue at both ends, then search, flip and pop.
    send_req(REQ_PUSH_FRONT, VAL_MAX);
    send_req(REQ_PUSH_BACK, VAL_MIN);
    send_req(REQ_SEARCH, VAL_NEG1);
    send_req(REQ_REVERSE, VAL_ZERO);
    send_req(REQ_POP_FRONT, VAL_ZERO);
    send_req(REQ_POP_BACK, VAL_ZERO);

    drain_pause();

    // Random: segments with a bias and their own idling style.
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      seg_len  = $urandom_range(20, 60);
      mode     = mix_mode_e'($urandom_range(0, 3));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < seg_len; k++) begin
        send_req(draw_request(mode), draw_value());
        sent++;
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        drain_pause();
        paused = 1'b1;
      end
    end

    // Wind down: let every result arrive, then watch for stray beats.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (4 * DEPTH) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS double_ended_queue_engine");
    end else begin
      $display("FAIL double_ended_queue_engine");
    end
    $finish;
  end

endmodule

`default_nettype wire
